// File: rtl/spimon_pkg.sv
// ----------------------------------------------------------------------------
// spimon_pkg: shared types and constants of the SPI bus monitor
// Symbol kinds, framer states and the command record that the framer
// hands to the emitter through the command queue.
// ----------------------------------------------------------------------------
package spimon_pkg;

  localparam int TimeW        = 63;
  localparam int ByteW        = 8;
  localparam int BitsPerByte  = 8;
  localparam int BitCntW      = 3;
  localparam int DefQueueDepth = 4;

  typedef enum logic [1:0] {
    KindSelect   = 2'd0,
    KindData     = 2'd1,
    KindDeselect = 2'd2
  } symbol_kind_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StDesel = 2'd1,
    StClkLo = 2'd2,
    StClkHi = 2'd3
  } framer_state_e;

  // One or two symbols caused by a single sample. The second symbol,
  // when present, is always a deselect with a zero byte.
  typedef struct packed {
    symbol_kind_e             kind_a;
    logic [ByteW-1:0]         byte_a;
    logic [TimeW-1:0]         start_a;
    logic [TimeW-1:0]         stop_a;
    logic                     two;
    logic [TimeW-1:0]         start_b;
    logic [TimeW-1:0]         stop_b;
  } cmd_t;

endpackage

// File: rtl/spimon_framer.sv
// ----------------------------------------------------------------------------
// spimon_framer: sample front end
// Tracks chip select and clock edges, shifts in bytes, holds back the last
// finished byte and issues one command item per sample that yields symbols.
// ----------------------------------------------------------------------------
module spimon_framer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       chip_select_n_i,
  input  logic                       serial_clock_i,
  input  logic                       serial_data_i,
  input  logic [spimon_pkg::TimeW-1:0] sample_time_i,
  output logic                       push_o,
  output spimon_pkg::cmd_t           cmd_o
);
  import spimon_pkg::*;

  framer_state_e        state_q, state_d;
  logic [ByteW-1:0]     shift_q, shift_d;
  logic [BitCntW-1:0]   cnt_q, cnt_d;
  logic [TimeW-1:0]     sym_start_q, sym_start_d;
  logic                 sel_unrep_q, sel_unrep_d;
  logic                 held_valid_q, held_valid_d;
  logic [ByteW-1:0]     held_byte_q, held_byte_d;
  logic [TimeW-1:0]     held_start_q, held_start_d;
  logic [TimeW-1:0]     held_end_q, held_end_d;

  logic                 emit;
  logic [TimeW-1:0]     sym_mid;
  logic [ByteW-1:0]     shift_new;

  // Next state
  always_comb begin
    state_d      = state_q;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    sym_start_d  = sym_start_q;
    sel_unrep_d  = sel_unrep_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    held_start_d = held_start_q;
    held_end_d   = held_end_q;
    sym_mid      = sym_start_q;
    shift_new    = {shift_q[ByteW-2:0], serial_data_i};
    case (state_q)
      StIdle: begin
        if (chip_select_n_i) state_d = StDesel;
      end
      StDesel: begin
        if (!chip_select_n_i) begin
          state_d     = StClkLo;
          shift_d     = '0;
          cnt_d       = '0;
          sym_start_d = sample_time_i;
          sel_unrep_d = 1'b1;
        end
      end
      StClkLo: begin
        if (serial_clock_i) begin
          if (cnt_q == '0) begin
            if (sel_unrep_q) begin
              sel_unrep_d = 1'b0;
            end else if (held_valid_q) begin
              held_valid_d = 1'b0;
            end
            sym_mid = sample_time_i;
          end
          state_d     = StClkHi;
          sym_start_d = sym_mid;
          if (cnt_q == BitCntW'(BitsPerByte - 1)) begin
            held_valid_d = 1'b1;
            held_byte_d  = shift_new;
            held_start_d = sym_mid;
            held_end_d   = sample_time_i;
            cnt_d        = '0;
            shift_d      = '0;
            sym_start_d  = sample_time_i;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            shift_d = shift_new;
          end
        end else if (chip_select_n_i) begin
          state_d      = StDesel;
          held_valid_d = 1'b0;
          sel_unrep_d  = 1'b0;
          shift_d      = '0;
          cnt_d        = '0;
          sym_start_d  = sample_time_i;
        end
      end
      default: begin
        if (!serial_clock_i) begin
          state_d = StClkLo;
        end else if (chip_select_n_i) begin
          state_d      = StDesel;
          held_valid_d = 1'b0;
          sel_unrep_d  = 1'b0;
          shift_d      = '0;
          cnt_d        = '0;
          sym_start_d  = sample_time_i;
        end
      end
    endcase
  end

  // Command output
  always_comb begin
    emit          = 1'b0;
    cmd_o.kind_a  = KindDeselect;
    cmd_o.byte_a  = '0;
    cmd_o.start_a = sym_start_q;
    cmd_o.stop_a  = sample_time_i;
    cmd_o.two     = 1'b0;
    cmd_o.start_b = sym_start_q;
    cmd_o.stop_b  = sample_time_i;
    case (state_q)
      StClkLo: begin
        if (serial_clock_i) begin
          if (cnt_q == '0) begin
            if (sel_unrep_q) begin
              emit         = 1'b1;
              cmd_o.kind_a = KindSelect;
            end else if (held_valid_q) begin
              emit          = 1'b1;
              cmd_o.kind_a  = KindData;
              cmd_o.byte_a  = held_byte_q;
              cmd_o.start_a = held_start_q;
            end
          end
        end else if (chip_select_n_i) begin
          emit = 1'b1;
          if (held_valid_q) begin
            cmd_o.kind_a  = KindData;
            cmd_o.byte_a  = held_byte_q;
            cmd_o.start_a = held_start_q;
            cmd_o.stop_a  = held_end_q;
            cmd_o.two     = 1'b1;
          end
        end
      end
      StClkHi: begin
        if (serial_clock_i && chip_select_n_i) begin
          emit = 1'b1;
          if (held_valid_q) begin
            cmd_o.kind_a  = KindData;
            cmd_o.byte_a  = held_byte_q;
            cmd_o.start_a = held_start_q;
            cmd_o.stop_a  = held_end_q;
            cmd_o.two     = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_o = accept_i && emit;

  // Framer registers: advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      shift_q      <= '0;
      cnt_q        <= '0;
      sym_start_q  <= '0;
      sel_unrep_q  <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
      held_start_q <= '0;
      held_end_q   <= '0;
    end else if (accept_i) begin
      state_q      <= state_d;
      shift_q      <= shift_d;
      cnt_q        <= cnt_d;
      sym_start_q  <= sym_start_d;
      sel_unrep_q  <= sel_unrep_d;
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      held_start_q <= held_start_d;
      held_end_q   <= held_end_d;
    end
  end

endmodule

// File: rtl/spimon_queue.sv
// ----------------------------------------------------------------------------
// spimon_queue: command queue
// Small circular buffer of command items between framer and emitter.
// ----------------------------------------------------------------------------
module spimon_queue #(
  parameter int Depth = spimon_pkg::DefQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  spimon_pkg::cmd_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output spimon_pkg::cmd_t rdata_o
);
  import spimon_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// File: rtl/spimon_emitter.sv
// ----------------------------------------------------------------------------
// spimon_emitter: symbol back end
// Unpacks each command item into one or two result items, computes the
// durations and holds each result in an output register until taken.
// ----------------------------------------------------------------------------
module spimon_emitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  spimon_pkg::cmd_t             cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   symbol_kind_o,
  output logic [spimon_pkg::ByteW-1:0] data_byte_o,
  output logic [spimon_pkg::TimeW-1:0] start_time_o,
  output logic [spimon_pkg::TimeW-1:0] duration_o,
  output logic                         last_in_run_o
);
  import spimon_pkg::*;

  logic             out_valid_q;
  logic             phase_q;
  logic             load;
  symbol_kind_e     sel_kind;
  logic [ByteW-1:0] sel_byte;
  logic [TimeW-1:0] sel_start, sel_stop;
  logic             sel_last;

  logic [1:0]       kind_q;
  logic [ByteW-1:0] byte_q;
  logic [TimeW-1:0] start_q, dur_q;
  logic             last_q;

  assign load      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = load && (phase_q || !cmd_i.two);

  // Pick the symbol of the head item for this phase
  always_comb begin
    if (phase_q) begin
      sel_kind  = KindDeselect;
      sel_byte  = '0;
      sel_start = cmd_i.start_b;
      sel_stop  = cmd_i.stop_b;
      sel_last  = 1'b1;
    end else begin
      sel_kind  = cmd_i.kind_a;
      sel_byte  = cmd_i.byte_a;
      sel_start = cmd_i.start_a;
      sel_stop  = cmd_i.stop_a;
      sel_last  = !cmd_i.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= !phase_q && cmd_i.two;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= sel_kind;
      byte_q  <= sel_byte;
      start_q <= sel_start;
      dur_q   <= sel_stop - sel_start;
      last_q  <= sel_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_kind_o = kind_q;
  assign data_byte_o   = byte_q;
  assign start_time_o  = start_q;
  assign duration_o    = dur_q;
  assign last_in_run_o = last_q;

endmodule

// File: rtl/spi_bus_monitor_decoder.sv
// Path: a sample's results pass a command queue entry, then the output register.
// Throughput: one sample per cycle; one result per cycle while out_ready_i is
//   high; a two-result sample keeps the queue head until both are loaded.
// The input stalls only when the QueueDepth-entry command queue is full.
// Reset (rst_ni low, asynchronous): framer waits for chip select high, queue
//   and output register empty.
// ----------------------------------------------------------------------------
// spi_bus_monitor_decoder: SPI mode 0 bus monitor
// Framer front end, command queue and symbol emitter back end.
// ----------------------------------------------------------------------------
module spi_bus_monitor_decoder #(
  parameter int QueueDepth = spimon_pkg::DefQueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         chip_select_n_i,
  input  logic                         serial_clock_i,
  input  logic                         serial_data_i,
  input  logic [spimon_pkg::TimeW-1:0] sample_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   symbol_kind_o,
  output logic [spimon_pkg::ByteW-1:0] data_byte_o,
  output logic [spimon_pkg::TimeW-1:0] start_time_o,
  output logic [spimon_pkg::TimeW-1:0] duration_o,
  output logic                         last_in_run_o
);
  import spimon_pkg::*;

  logic accept;
  logic push, full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  spimon_framer u_framer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .chip_select_n_i (chip_select_n_i),
    .serial_clock_i  (serial_clock_i),
    .serial_data_i   (serial_data_i),
    .sample_time_i   (sample_time_i),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  spimon_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_cmd)
  );

  spimon_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_kind_o (symbol_kind_o),
    .data_byte_o   (data_byte_o),
    .start_time_o  (start_time_o),
    .duration_o    (duration_o),
    .last_in_run_o (last_in_run_o)
  );

endmodule
